// ----- src/dvc_pkg.sv -----
package dvc_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned SLOT_FLD_W  = 6;
  localparam int unsigned COUNT_FLD_W = 7;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic                   is_new;
    logic [SLOT_FLD_W-1:0]  slot;
    logic [COUNT_FLD_W-1:0] distinct_count;
    logic                   overflow;
    logic                   done_res;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_e;

endpackage

// ----- src/dvc_cell.sv -----
module dvc_cell #(
  parameter int unsigned SlotW   = 6,
  parameter int unsigned CountW  = 7,
  parameter int unsigned CellIdx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dvc_pkg::ELEM_W-1:0] elem_i,
  input  logic [CountW-1:0]          count_i,
  input  logic                       wr_en_i,
  input  logic [SlotW-1:0]           wr_idx_i,
  input  logic                       tok_vld_i,
  input  logic                       tok_hit_i,
  input  logic [SlotW-1:0]           tok_slot_i,
  output logic                       tok_vld_o,
  output logic                       tok_hit_o,
  output logic [SlotW-1:0]           tok_slot_o
);
  import dvc_pkg::*;

  logic [ELEM_W-1:0] value_q;
  logic              occupied;
  logic              match;
  logic              tok_vld_q;
  logic              tok_hit_q, tok_hit_d;
  logic [SlotW-1:0]  tok_slot_q, tok_slot_d;

  assign occupied   = CountW'(CellIdx) < count_i;
  assign match      = occupied && (value_q == elem_i);
  assign tok_hit_d  = tok_hit_i || match;
  assign tok_slot_d = match ? SlotW'(CellIdx) : tok_slot_i;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == SlotW'(CellIdx))) begin
      value_q <= elem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_hit_q  <= tok_hit_d;
    tok_slot_q <= tok_slot_d;
  end

  assign tok_vld_o  = tok_vld_q;
  assign tok_hit_o  = tok_hit_q;
  assign tok_slot_o = tok_slot_q;

endmodule

// ----- src/distinct_value_collector.sv -----
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------
// item     | in        | start high and busy low   | item_i (element, last)
// result   | out       | res_valid_o, one cycle    | res_o (is_new, slot,
//          |           |                           |  distinct_count, ...)
//
// The result strobe follows the search of an accepted item, and the next item can be
// accepted at the edge that ends the strobe, so only one item is searched at a time.
// The search time is set by the search token, which walks the row of Capacity
// compare cells one cell per cycle.
// Reset clears the distinct count and the control state; stored values need none.
// The receiver cannot stall; busy is high from acceptance until the result strobe.
module distinct_value_collector #(
  parameter int unsigned Capacity = dvc_pkg::CAPACITY
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dvc_pkg::item_t item_i,
  output logic           res_valid_o,
  output dvc_pkg::res_t  res_o
);
  import dvc_pkg::*;

  localparam int unsigned SlotW  = $clog2(Capacity);
  localparam int unsigned CountW = $clog2(Capacity + 1);

  state_e            state_q, state_d;
  logic [ELEM_W-1:0] elem_q;
  logic              last_q;
  logic              launch_q;
  logic [CountW-1:0] count_q, count_d;
  logic              res_valid_q;
  res_t              res_q, res_d;

  logic [Capacity:0] vld_w;
  logic [Capacity:0] hit_w;
  logic [SlotW-1:0]  slot_w [Capacity+1];

  logic              accept;
  logic              end_vld;
  logic              positive;
  logic              full;
  logic              append;
  logic              drop;
  logic [SlotW-1:0]  slot_sel;
  logic [CountW-1:0] count_after;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_SEARCH);

  assign vld_w[0]  = launch_q;
  assign hit_w[0]  = 1'b0;
  assign slot_w[0] = '0;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    dvc_cell #(
      .SlotW  (SlotW),
      .CountW (CountW),
      .CellIdx(g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .elem_i    (elem_q),
      .count_i   (count_q),
      .wr_en_i   (append),
      .wr_idx_i  (count_q[SlotW-1:0]),
      .tok_vld_i (vld_w[g]),
      .tok_hit_i (hit_w[g]),
      .tok_slot_i(slot_w[g]),
      .tok_vld_o (vld_w[g+1]),
      .tok_hit_o (hit_w[g+1]),
      .tok_slot_o(slot_w[g+1])
    );
  end

  assign end_vld     = vld_w[Capacity];
  assign positive    = !elem_q[ELEM_W-1] && (elem_q != '0);
  assign full        = (count_q == CountW'(Capacity));
  assign append      = end_vld && positive && !hit_w[Capacity] && !full;
  assign drop        = positive && !hit_w[Capacity] && full;
  assign count_after = count_q + CountW'(append);

  always_comb begin
    if (positive && hit_w[Capacity]) begin
      slot_sel = slot_w[Capacity];
    end else if (append) begin
      slot_sel = count_q[SlotW-1:0];
    end else begin
      slot_sel = '0;
    end
  end

  always_comb begin
    res_d.is_new         = append;
    res_d.slot           = SLOT_FLD_W'(slot_sel);
    res_d.distinct_count = COUNT_FLD_W'(count_after);
    res_d.overflow       = drop;
    res_d.done_res       = last_q;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (end_vld) begin
          state_d = ST_IDLE;
          count_d = last_q ? '0 : count_after;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      launch_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      launch_q    <= accept;
      res_valid_q <= end_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elem_q <= item_i.element;
      last_q <= item_i.last;
    end
    if (end_vld) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_w))
    else $error("More than one search token is in the cell row.");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_w != '0) |-> busy)
    else $error("A search token moves while the block is idle.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Capacity))
    else $error("The distinct count exceeds the capacity.");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("Two results were strobed in consecutive cycles.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("An accepted item did not raise busy.");
`endif

endmodule
